// ===== hdl/slot_allocator_with_reuse_delay_macros.svh =====
// ---------------------------------------------------------------------------
// Slot allocator assertion macros
// Concurrent assertion helpers shared by the slot allocator RTL.
// ---------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_WITH_REUSE_DELAY_MACROS_SVH
`define SLOT_ALLOCATOR_WITH_REUSE_DELAY_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define SARD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot allocator assertion failed");
// Next-cycle implication, disabled while reset is high.
`define SARD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot allocator assertion failed");
`else
`define SARD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SARD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/sard_pkg.sv =====
// ---------------------------------------------------------------------------
// Slot allocator package
// Sizes, status and register codes, and the slot table entry layout.
// ---------------------------------------------------------------------------
package sard_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = 10;
  localparam int HW_W      = $clog2(MAX_SLOTS + 1);
  localparam int TIME_W    = 32;
  localparam int SER_W     = 16;
  localparam int DELAY_W   = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_DOUBLE = 2'd2;
  localparam logic [1:0] ST_BAD    = 2'd3;

  localparam logic [1:0] CFG_FIRST_SLOT  = 2'd0;
  localparam logic [1:0] CFG_MAX_SLOTS   = 2'd1;
  localparam logic [1:0] CFG_REUSE_DELAY = 2'd2;
  localparam logic [1:0] CFG_GRACE_TIME  = 2'd3;

  // One slot table entry, kept in a single RAM word.
  typedef struct packed {
    logic              free;
    logic [TIME_W-1:0] freed_at;
    logic [SER_W-1:0]  serial;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Timing settings used by the reuse check.
  typedef struct packed {
    logic [DELAY_W-1:0] reuse_delay;
    logic [DELAY_W-1:0] grace_time;
  } reuse_cfg_t;

endpackage

// ===== hdl/sard_ram.sv =====
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module sard_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sard_reuse.sv =====
// ---------------------------------------------------------------------------
// Slot reuse check
// Decides whether a table entry may be handed out again at the given time.
// ---------------------------------------------------------------------------
module sard_reuse (
  input  sard_pkg::entry_t                 entry,
  input  logic [sard_pkg::TIME_W-1:0]      now,
  input  sard_pkg::reuse_cfg_t             cfg,
  output logic                             reusable
);

  logic [sard_pkg::TIME_W-1:0] rest;
  logic [sard_pkg::TIME_W-1:0] grace_ext;
  logic [sard_pkg::TIME_W-1:0] delay_ext;

  assign rest      = now - entry.freed_at;
  assign grace_ext = {{(sard_pkg::TIME_W - sard_pkg::DELAY_W){1'b0}}, cfg.grace_time};
  assign delay_ext = {{(sard_pkg::TIME_W - sard_pkg::DELAY_W){1'b0}}, cfg.reuse_delay};

  // A slot freed early enough is reusable at once; otherwise it must have
  // rested longer than the delay, with time running backward counting as no rest.
  assign reusable = entry.free &&
                    ((entry.freed_at < grace_ext) ||
                     ((now >= entry.freed_at) && (rest > delay_ext)));

endmodule

// ===== hdl/slot_allocator_with_reuse_delay.sv =====
// ---------------------------------------------------------------------------
// Slot allocator with reuse delay
// First-fit slot allocator over a 1024-entry table held in one RAM.
// ---------------------------------------------------------------------------
// A bad-index free goes straight to S_DONE; other frees pass through S_FREE,
// and an allocate scans in S_SCAN, reading one table entry per cycle from
// first_slot up to the high-water mark, then adds one more RAM read in S_GROW
// when the table grows. One transaction at a time; the next is taken the cycle
// after the result is loaded. Reset starts a clearing pass over every table
// entry; no input is taken until it ends.
module slot_allocator_with_reuse_delay (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // slot_in[9:0], now[41:10], zero fill
  input  logic        s_tuser,   // operation
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // slot_out[9:0], status[11:10], serial[27:12], zero fill
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SLOT_W = sard_pkg::SLOT_W;
  localparam int HW_W   = sard_pkg::HW_W;
  localparam int TIME_W = sard_pkg::TIME_W;
  localparam int SER_W  = sard_pkg::SER_W;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_GROW  = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state;
  logic [SLOT_W-1:0] clr_cnt;

  // Configuration registers.
  logic [SLOT_W-1:0]    first_slot;
  logic [HW_W-1:0]      max_slots;
  sard_pkg::reuse_cfg_t reuse_cfg;

  logic [HW_W-1:0] high_water;

  // Current transaction.
  logic [TIME_W-1:0] op_now;
  logic [HW_W-1:0]   scan_ptr;   // next address the scan reads
  logic              pend;       // a scan read is in flight
  logic [SLOT_W-1:0] pend_addr;  // address of the in-flight read

  // Result waiting for the output register.
  logic [SLOT_W-1:0] res_slot;
  logic [1:0]        res_status;
  logic [SER_W-1:0]  res_serial;

  // RAM ports.
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  sard_pkg::entry_t    ram_wdata;
  logic [SLOT_W-1:0]   ram_raddr;
  sard_pkg::entry_t    ram_rdata;

  logic              in_fire;
  logic              in_op;
  logic [SLOT_W-1:0] in_slot;
  logic [TIME_W-1:0] in_now;
  logic              reusable;
  logic              hit;
  logic              scan_more;
  logic [HW_W-1:0]   first_ext;
  logic [HW_W-1:0]   grow_slot;
  logic [HW_W-1:0]   limit;
  logic              out_free;

  assign in_op   = s_tuser;
  assign in_slot = s_tdata[9:0];
  assign in_now  = s_tdata[41:10];

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign first_ext = {{(HW_W - SLOT_W){1'b0}}, first_slot};
  assign grow_slot = (first_ext > high_water) ? first_ext : high_water;
  assign limit     = (max_slots > HW_W'(sard_pkg::MAX_SLOTS)) ?
                     HW_W'(sard_pkg::MAX_SLOTS) : max_slots;

  assign hit       = pend && reusable;
  assign scan_more = scan_ptr < high_water;

  sard_reuse u_reuse (
    .entry    (ram_rdata),
    .now      (op_now),
    .cfg      (reuse_cfg),
    .reusable (reusable)
  );

  sard_ram #(
    .WIDTH (sard_pkg::ENTRY_W),
    .DEPTH (sard_pkg::MAX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM addressing. No read issued in the cycle an entry is written is used:
  // outside the clearing pass, every write ends a transaction, and the next one
  // starts only after the result has been passed on.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    ram_raddr = pend_addr;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_raddr = in_slot;
      end
      S_SCAN: begin
        if (hit) begin
          // Take the slot: only the free flag changes.
          ram_we         = 1'b1;
          ram_wdata.free = 1'b0;
        end
        ram_raddr = scan_more ? scan_ptr[SLOT_W-1:0] : grow_slot[SLOT_W-1:0];
      end
      S_GROW: begin
        ram_we         = 1'b1;
        ram_wdata.free = 1'b0;
      end
      S_FREE: begin
        ram_we             = 1'b1;
        ram_wdata.free     = 1'b1;
        ram_wdata.freed_at = op_now;
        ram_wdata.serial   = ram_rdata.serial + SER_W'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_slot            <= SLOT_W'(1);
      max_slots             <= HW_W'(1024);
      reuse_cfg.reuse_delay <= 16'd500;
      reuse_cfg.grace_time  <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sard_pkg::CFG_FIRST_SLOT:  first_slot            <= cfg_data[SLOT_W-1:0];
        sard_pkg::CFG_MAX_SLOTS:   max_slots             <= cfg_data[HW_W-1:0];
        sard_pkg::CFG_REUSE_DELAY: reuse_cfg.reuse_delay <= cfg_data;
        sard_pkg::CFG_GRACE_TIME:  reuse_cfg.grace_time  <= cfg_data;
      endcase
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      high_water <= '0;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // The output register fills when a finished transaction leaves S_DONE
      // and empties when its result is taken.
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + SLOT_W'(1);
          if (clr_cnt == SLOT_W'(sard_pkg::MAX_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            op_now    <= in_now;
            pend      <= 1'b0;
            scan_ptr  <= first_ext;
            pend_addr <= in_slot;
            if (in_op == sard_pkg::OP_ALLOC) begin
              state <= S_SCAN;
            end else if ({{(HW_W - SLOT_W){1'b0}}, in_slot} >= high_water) begin
              // Free of a slot the table never reached.
              res_slot   <= in_slot;
              res_status <= sard_pkg::ST_BAD;
              res_serial <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_FREE;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_slot   <= pend_addr;
            res_status <= sard_pkg::ST_OK;
            res_serial <= ram_rdata.serial;
            pend       <= 1'b0;
            state      <= S_DONE;
          end else if (scan_more) begin
            pend      <= 1'b1;
            pend_addr <= scan_ptr[SLOT_W-1:0];
            scan_ptr  <= scan_ptr + HW_W'(1);
          end else begin
            pend <= 1'b0;
            if (grow_slot < limit) begin
              pend_addr <= grow_slot[SLOT_W-1:0];
              state     <= S_GROW;
            end else begin
              res_slot   <= '0;
              res_status <= sard_pkg::ST_NONE;
              res_serial <= '0;
              state      <= S_DONE;
            end
          end
        end
        S_GROW: begin
          high_water <= {{(HW_W - SLOT_W){1'b0}}, pend_addr} + HW_W'(1);
          res_slot   <= pend_addr;
          res_status <= sard_pkg::ST_OK;
          res_serial <= ram_rdata.serial;
          state      <= S_DONE;
        end
        S_FREE: begin
          res_slot   <= pend_addr;
          res_status <= ram_rdata.free ? sard_pkg::ST_DOUBLE : sard_pkg::ST_OK;
          res_serial <= ram_rdata.serial + SER_W'(1);
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload is loaded together with the valid flag.
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {4'b0, res_serial, res_status, res_slot};
    end
  end

`include "slot_allocator_with_reuse_delay_macros.svh"

  // The table never grows past its size.
  `SARD_ASSERT_IMPLIES(a_hw_bound, clk, rst, 1'b1, high_water <= HW_W'(sard_pkg::MAX_SLOTS))
  // A scan only looks at entries below the high-water mark.
  `SARD_ASSERT_IMPLIES(a_scan_range, clk, rst, state == S_SCAN && pend, HW_W'(pend_addr) < high_water)
  // An accepted input transaction always leaves the idle state.
  `SARD_ASSERT_NEXT(a_accept_busy, clk, rst, s_tvalid && s_tready, state != S_IDLE)

endmodule
